FILE: design/tced_pkg.sv
package tced_pkg;

    localparam int FLOOR_W     = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FLOOR_W-1:0] MAX_FLOOR = FLOOR_W'(255);

    typedef struct packed {
        logic               call_valid;
        logic [FLOOR_W-1:0] call_floor;
    } call_t;

    typedef struct packed {
        logic [FLOOR_W-1:0] car_one_floor;
        logic [FLOOR_W-1:0] car_two_floor;
        logic               car_one_arrived;
        logic               car_two_arrived;
        logic               assigned_car;
        logic               call_dropped;
        logic               car_one_up;
        logic               car_two_up;
    } result_t;

    // dispatcher to car: what to do at the end of this tick
    typedef struct packed {
        logic               ins_en;
        logic [FLOOR_W-1:0] ins_floor;
        logic               set_dir;
        logic               dir_up;
        logic               park;
        logic [FLOOR_W-1:0] park_floor;
    } car_ctrl_t;

    // car to dispatcher: view after this tick's move and pop
    typedef struct packed {
        logic [FLOOR_W-1:0] floor;
        logic               up;
        logic               empty;
        logic               full;
        logic               arrived;
    } car_status_t;

endpackage

FILE: design/tced_cell.sv
module tced_cell
    import tced_pkg::*;
(
    input  logic               clk,
    input  logic               tick,
    input  logic               pop,
    input  logic               occupied,
    input  logic               ins_en,
    input  logic [FLOOR_W-1:0] ins_floor,
    input  logic               up,
    input  logic [FLOOR_W-1:0] right_stop,
    input  logic [FLOOR_W-1:0] left_post,
    input  logic               found_in,
    output logic [FLOOR_W-1:0] stop,
    output logic [FLOOR_W-1:0] post,
    output logic               found_out
);

    logic [FLOOR_W-1:0] stop_reg;
    logic [FLOOR_W-1:0] stop_next;
    logic               beyond;
    logic               take_here;

    assign stop = stop_reg;
    assign post = pop ? right_stop : stop_reg;

    // new floor goes before the first stop that lies past it, or at the tail
    assign beyond    = !occupied || (up ? (post > ins_floor) : (post < ins_floor));
    assign take_here = ins_en && !found_in && beyond;
    assign found_out = found_in || take_here;

    always_comb
    begin
        if (found_in)
            stop_next = left_post;
        else if (take_here)
            stop_next = ins_floor;
        else
            stop_next = post;
    end

    always_ff @(posedge clk)
    begin
        if (tick)
            stop_reg <= stop_next;
    end

endmodule

FILE: design/tced_car.sv
module tced_car
    import tced_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        home_up,
    input  logic        tick,
    input  car_ctrl_t   ctrl,
    output car_status_t status
);

    logic [FLOOR_W-1:0] pos_reg;
    logic [FLOOR_W-1:0] pos_next;
    logic               up_reg;
    logic               up_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic [FLOOR_W-1:0] pos_post;
    logic [FLOOR_W-1:0] head;
    logic               busy_q;
    logic               pop;
    logic [CNT_W-1:0]   count_post;
    logic               ins_up;

    logic [FLOOR_W-1:0] stop_w  [QUEUE_DEPTH];
    logic [FLOOR_W-1:0] post_w  [QUEUE_DEPTH];
    logic               found_w [QUEUE_DEPTH];

    assign head   = stop_w[0];
    assign busy_q = (count_reg != '0);

    always_comb
    begin
        pos_post = pos_reg;
        if (busy_q)
        begin
            if (pos_reg < head)
                pos_post = pos_reg + FLOOR_W'(1);
            else if (pos_reg > head)
                pos_post = pos_reg - FLOOR_W'(1);
        end
    end

    assign pop        = tick && busy_q && (pos_post == head);
    assign count_post = count_reg - CNT_W'(pop);
    assign ins_up     = ctrl.set_dir ? ctrl.dir_up : up_reg;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic [FLOOR_W-1:0] right_s;
            logic [FLOOR_W-1:0] left_p;
            logic               found_l;

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_s = stop_w[i];
            end
            else
            begin : g_mid
                assign right_s = stop_w[i+1];
            end

            if (i == 0)
            begin : g_head
                assign left_p  = post_w[i];
                assign found_l = 1'b0;
            end
            else
            begin : g_body
                assign left_p  = post_w[i-1];
                assign found_l = found_w[i-1];
            end

            tced_cell u_cell (
                .clk        (clk),
                .tick       (tick),
                .pop        (pop),
                .occupied   (count_post > CNT_W'(i)),
                .ins_en     (ctrl.ins_en),
                .ins_floor  (ctrl.ins_floor),
                .up         (ins_up),
                .right_stop (right_s),
                .left_post  (left_p),
                .found_in   (found_l),
                .stop       (stop_w[i]),
                .post       (post_w[i]),
                .found_out  (found_w[i])
            );
        end
    endgenerate

    always_comb
    begin
        pos_next   = pos_reg;
        up_next    = up_reg;
        count_next = count_reg;
        if (ctrl.park)
            pos_next = ctrl.park_floor;
        else if (tick)
        begin
            pos_next   = pos_post;
            up_next    = ins_up;
            count_next = count_post + CNT_W'(ctrl.ins_en);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= FLOOR_W'(1);
            up_reg    <= home_up;
            count_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            up_reg    <= up_next;
            count_reg <= count_next;
        end
    end

    assign status.floor   = pos_post;
    assign status.up      = up_reg;
    assign status.empty   = (count_post == '0);
    assign status.full    = (count_post >= CNT_W'(QUEUE_DEPTH));
    assign status.arrived = pop;

endmodule

FILE: design/two_car_elevator_dispatcher.sv
// Two-car elevator dispatcher.
//
// Input channel: drive call and raise start for one cycle per tick; the tick
// is taken at the rising edge where start is high and busy is low. busy stays
// low, so a tick can be taken in every cycle.
// Result channel: one result word per tick, on result with done high for
// exactly one cycle, the cycle right after the tick is taken (throughput one
// tick per cycle). The receiver cannot stall; a word not
// captured in its cycle is gone.
// Each tick moves each car with stops one floor toward its head, pops an
// arrived head stop, then files the hall call into one car's sorted stop
// row. Each row is a chain of cells that shift on pop and open a slot on
// insert in the same cycle; the ripple through the row sets the cycle time.
// Configuration: top_floor_we with top_floor_wdata writes the top floor and
// parks car two there; a write of zero is ignored. Write only while idle.
// Reset: car one at floor 1 going up, car two at floor 1 going down, top
// floor 1, both stop rows empty, no result pending.
module two_car_elevator_dispatcher
    import tced_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  call_t              call,
    output logic               done,
    output result_t            result,
    input  logic               top_floor_we,
    input  logic [FLOOR_W-1:0] top_floor_wdata
);

    logic [FLOOR_W-1:0] top_reg;
    logic [FLOOR_W-1:0] top_next;
    logic               done_reg;
    result_t            result_reg;

    logic               tick;
    logic               hit;
    logic               park;
    logic [FLOOR_W-1:0] call_fl;
    car_status_t        st1;
    car_status_t        st2;
    car_ctrl_t          ctl1;
    car_ctrl_t          ctl2;

    logic [FLOOR_W-1:0] d1;
    logic [FLOOR_W-1:0] d2;
    logic               near_one;
    logic signed [FLOOR_W:0] sa;
    logic signed [FLOOR_W:0] sb;
    logic               sel;
    logic               set1;
    logic               set2;
    logic               dirv1;
    logic               dirv2;
    logic               drop;

    assign busy = 1'b0;
    assign tick = start && !busy;
    assign hit  = tick && call.call_valid;

    assign park = top_floor_we && (top_floor_wdata != '0);
    assign top_next = (top_floor_wdata > MAX_FLOOR) ? MAX_FLOOR : top_floor_wdata;

    always_comb
    begin
        if (call.call_floor == '0)
            call_fl = FLOOR_W'(1);
        else if (call.call_floor > top_reg)
            call_fl = top_reg;
        else
            call_fl = call.call_floor;
    end

    assign d1 = (st1.floor > call_fl) ? st1.floor - call_fl : call_fl - st1.floor;
    assign d2 = (st2.floor > call_fl) ? st2.floor - call_fl : call_fl - st2.floor;
    assign near_one = (d1 <= d2);

    // signed gap rule when the cars head opposite ways
    always_comb
    begin
        if (st1.up)
        begin
            sa = $signed({1'b0, st1.floor}) - $signed({1'b0, call_fl});
            sb = $signed({1'b0, call_fl}) - $signed({1'b0, st2.floor});
        end
        else
        begin
            sa = $signed({1'b0, call_fl}) - $signed({1'b0, st1.floor});
            sb = $signed({1'b0, st2.floor}) - $signed({1'b0, call_fl});
        end
    end

    always_comb
    begin
        sel   = !near_one;
        set1  = 1'b0;
        set2  = 1'b0;
        dirv1 = (st1.floor <= call_fl);
        dirv2 = (st2.floor <= call_fl);
        if (!st1.empty && !st2.empty)
        begin
            if (st1.up != st2.up)
                sel = !(sa <= sb);
        end
        else if (st1.empty && !st2.empty)
        begin
            set1 = near_one;
        end
        else if (!st1.empty && st2.empty)
        begin
            set2 = !near_one;
        end
    end

    assign drop = hit && (sel ? st2.full : st1.full);

    always_comb
    begin
        ctl1            = '0;
        ctl1.ins_en     = hit && !sel && !st1.full;
        ctl1.ins_floor  = call_fl;
        ctl1.set_dir    = hit && set1;
        ctl1.dir_up     = dirv1;
        ctl2            = '0;
        ctl2.ins_en     = hit && sel && !st2.full;
        ctl2.ins_floor  = call_fl;
        ctl2.set_dir    = hit && set2;
        ctl2.dir_up     = dirv2;
        ctl2.park       = park;
        ctl2.park_floor = top_next;
    end

    tced_car u_car_one (
        .clk     (clk),
        .rst_n   (rst_n),
        .home_up (1'b1),
        .tick    (tick),
        .ctrl    (ctl1),
        .status  (st1)
    );

    tced_car u_car_two (
        .clk     (clk),
        .rst_n   (rst_n),
        .home_up (1'b0),
        .tick    (tick),
        .ctrl    (ctl2),
        .status  (st2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= FLOOR_W'(1);
            done_reg <= 1'b0;
        end
        else
        begin
            if (park)
                top_reg <= top_next;
            done_reg <= tick;
        end
    end

    // register the word on each tick; it holds until the next tick
    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            result_reg.car_one_floor   <= st1.floor;
            result_reg.car_two_floor   <= st2.floor;
            result_reg.car_one_arrived <= st1.arrived;
            result_reg.car_two_arrived <= st2.arrived;
            result_reg.assigned_car    <= hit && sel;
            result_reg.call_dropped    <= drop;
            result_reg.car_one_up      <= ctl1.set_dir ? ctl1.dir_up : st1.up;
            result_reg.car_two_up      <= ctl2.set_dir ? ctl2.dir_up : st2.up;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_follows_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("result word missing after accepted tick");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !start |=> !done)
        else $error("result word without a tick");

    a_no_call_no_assign: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !call.call_valid) |=>
            (!result.assigned_car && !result.call_dropped))
        else $error("call fields set on a tick without a call");

    a_drop_not_both_arrive: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.call_dropped) |-> !(result.assigned_car ?
            result.car_two_arrived : result.car_one_arrived))
        else $error("call dropped on a queue that just popped");

endmodule

FILE: tb/tb_two_car_elevator_dispatcher.sv
module tb_two_car_elevator_dispatcher;
    import tced_pkg::*;

    typedef enum logic {ROW_CALL, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               valid;
        logic [FLOOR_W-1:0] value;
        logic               typed;
        result_t            want;
    } plan_row_t;

    localparam int N_PLAN       = 26;
    localparam int N_PHASE      = 6;
    localparam int PHASE_WORDS  = 300;
    localparam int DRAIN_CYCLES = 50;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    call_t              call;
    logic               done;
    result_t            result;
    logic               top_floor_we;
    logic [FLOOR_W-1:0] top_floor_wdata;

    // shadow of the cars, updated on each accepted tick and top-floor write
    int car_pos [2];
    bit car_up [2];
    int car_cnt [2];
    int car_stops [2][QUEUE_DEPTH];
    int top_floor_m;

    result_t pending_results [$];
    logic    use_typed;
    result_t typed_word;

    int n_taken;
    int n_calls;
    int n_drops;
    int n_arrivals;
    int n_cfg;
    int n_fail;

    two_car_elevator_dispatcher dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .call            (call),
        .done            (done),
        .result          (result),
        .top_floor_we    (top_floor_we),
        .top_floor_wdata (top_floor_wdata)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic bit move_car(int k);
        int head;
        if (car_cnt[k] == 0)
            return 1'b0;
        head = car_stops[k][0];
        if (car_pos[k] < head)
            car_pos[k]++;
        else if (car_pos[k] > head)
            car_pos[k]--;
        if (car_pos[k] != head)
            return 1'b0;
        for (int i = 0; i < car_cnt[k] - 1; i++)
            car_stops[k][i] = car_stops[k][i + 1];
        car_cnt[k]--;
        return 1'b1;
    endfunction

    function automatic result_t predict_tick(call_t c);
        result_t r;
        int      fl;
        int      d1;
        int      d2;
        int      pick;
        int      slot;
        bit      near_one;
        r = '0;
        r.car_one_arrived = move_car(0);
        r.car_two_arrived = move_car(1);
        if (c.call_valid)
        begin
            fl = int'(c.call_floor);
            if (fl < 1)
                fl = 1;
            if (fl > top_floor_m)
                fl = top_floor_m;
            d1 = car_pos[0] > fl ? car_pos[0] - fl : fl - car_pos[0];
            d2 = car_pos[1] > fl ? car_pos[1] - fl : fl - car_pos[1];
            near_one = d1 <= d2;
            pick = near_one ? 0 : 1;
            if (car_cnt[0] != 0 && car_cnt[1] != 0)
            begin
                // same direction: nearer car; opposite directions: signed reach toward the call decides
                if (car_up[0] == car_up[1])
                    pick = near_one ? 0 : 1;
                else if (!car_up[0])
                    pick = ((fl - car_pos[0]) <= (car_pos[1] - fl)) ? 0 : 1;
                else
                    pick = ((car_pos[0] - fl) <= (fl - car_pos[1])) ? 0 : 1;
            end
            else if (car_cnt[0] == 0 && car_cnt[1] != 0)
            begin
                if (near_one)
                    car_up[0] = car_pos[0] > fl ? 1'b0 : 1'b1;
            end
            else if (car_cnt[0] != 0 && car_cnt[1] == 0)
            begin
                if (!near_one)
                    car_up[1] = car_pos[1] > fl ? 1'b0 : 1'b1;
            end
            r.assigned_car = pick[0];
            if (car_cnt[pick] >= QUEUE_DEPTH)
            begin
                r.call_dropped = 1'b1;
            end
            else
            begin
                slot = 0;
                while (slot < car_cnt[pick] &&
                       !(car_up[pick] ? car_stops[pick][slot] > fl
                                      : car_stops[pick][slot] < fl))
                    slot++;
                for (int i = car_cnt[pick]; i > slot; i--)
                    car_stops[pick][i] = car_stops[pick][i - 1];
                car_stops[pick][slot] = fl;
                car_cnt[pick]++;
            end
        end
        r.car_one_floor = FLOOR_W'(car_pos[0]);
        r.car_two_floor = FLOOR_W'(car_pos[1]);
        r.car_one_up    = car_up[0];
        r.car_two_up    = car_up[1];
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    n_fail++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("car_one_floor", want.car_one_floor, result.car_one_floor);
                    check_field("car_two_floor", want.car_two_floor, result.car_two_floor);
                    check_field("car_one_arrived", want.car_one_arrived,
                                result.car_one_arrived);
                    check_field("car_two_arrived", want.car_two_arrived,
                                result.car_two_arrived);
                    check_field("assigned_car", want.assigned_car, result.assigned_car);
                    check_field("call_dropped", want.call_dropped, result.call_dropped);
                    check_field("car_one_up", want.car_one_up, result.car_one_up);
                    check_field("car_two_up", want.car_two_up, result.car_two_up);
                    n_drops += result.call_dropped;
                    n_arrivals += result.car_one_arrived + result.car_two_arrived;
                end
            end
            if (start && !busy)
            begin
                want = predict_tick(call);
                if (use_typed)
                    want = typed_word;
                pending_results.push_back(want);
                n_taken++;
                if (call.call_valid)
                    n_calls++;
            end
        end
    end

    // hold the word on the port until the block takes it
    task automatic send_word(logic valid, logic [FLOOR_W-1:0] floor);
        int    target;
        call_t w;
        target = n_taken + 1;
        w.call_valid = valid;
        w.call_floor = floor;
        start <= 1'b1;
        call  <= w;
        do
            @(negedge clk);
        while (n_taken < target);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        start <= 1'b0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (pending_results.size() != 0 && waited < DRAIN_CYCLES);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected words never arrived", pending_results.size());
            n_fail += pending_results.size();
            pending_results.delete();
        end
    endtask

    task automatic write_top(logic [FLOOR_W-1:0] v);
        drain_results();
        @(negedge clk);
        top_floor_we    <= 1'b1;
        top_floor_wdata <= v;
        if (v != '0)
        begin
            top_floor_m = int'(v);
            car_pos[1]  = int'(v);
        end
        n_cfg++;
        @(negedge clk);
        top_floor_we <= 1'b0;
    endtask

    initial
    begin
        plan_row_t          plan [N_PLAN];
        logic [FLOOR_W-1:0] phase_top [N_PHASE];
        int                 phase_gap [N_PHASE];
        logic [FLOOR_W-1:0] fl;
        logic               cv;
        int                 pick;

        start           = 1'b0;
        call            = '0;
        top_floor_we    = 1'b0;
        top_floor_wdata = '0;
        rst_n           = 1'b0;
        use_typed       = 1'b0;
        typed_word      = '0;
        n_taken         = 0;
        n_calls         = 0;
        n_drops         = 0;
        n_arrivals      = 0;
        n_cfg           = 0;
        n_fail          = 0;
        top_floor_m     = 1;
        car_pos         = '{1, 1};
        car_up          = '{1'b1, 1'b0};
        car_cnt         = '{0, 0};

        // typed words: {car one floor, car two floor,
        //               arrived 1, arrived 2, assigned, dropped, up 1, up 2}
        plan = '{
            '{ROW_CALL, 1'b1, 8'd0,   1'b1, {8'd1, 8'd1,   6'b000010}},
            '{ROW_CALL, 1'b0, 8'd0,   1'b1, {8'd1, 8'd1,   6'b100010}},
            '{ROW_CALL, 1'b1, 8'd255, 1'b1, {8'd1, 8'd1,   6'b000010}},
            '{ROW_CFG,  1'b0, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b1, {8'd1, 8'd255, 6'b101010}},
            '{ROW_CALL, 1'b1, 8'd128, 1'b1, {8'd1, 8'd255, 6'b010010}},
            '{ROW_CALL, 1'b1, 8'd200, 1'b1, {8'd2, 8'd255, 6'b001010}},
            // pile duplicate top-floor stops onto car one until it overflows
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd255, 1'b0, '0},
            '{ROW_CALL, 1'b0, 8'hAA,  1'b0, '0},
            '{ROW_CALL, 1'b1, 8'd0,   1'b0, '0}
        };

        // lowered top, ignored zero, raised top, random, floor one, middle
        phase_top = '{8'd8, 8'd0, 8'd255, 8'd0, 8'd1, 8'd40};
        phase_top[3] = FLOOR_W'($urandom_range(2, 254));
        phase_gap = '{0, 48, 0, 26, 48, 26};

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_PLAN; i++)
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                write_top(plan[i].value);
            end
            else
            begin
                use_typed  = plan[i].typed;
                typed_word = plan[i].want;
                send_word(plan[i].valid, plan[i].value);
                use_typed  = 1'b0;
            end
        end

        for (int p = 0; p < N_PHASE; p++)
        begin
            write_top(phase_top[p]);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                if (k == PHASE_WORDS / 2)
                    drain_results();
                // idle each cycle with the phase's odds
                while ($urandom_range(1, 100) <= phase_gap[p])
                begin
                    start <= 1'b0;
                    @(negedge clk);
                end
                cv = ($urandom_range(0, 9) != 0);
                pick = $urandom_range(0, 9);
                if (pick <= 6)
                    fl = FLOOR_W'($urandom_range(1, top_floor_m));
                else if (pick == 7)
                    fl = '0;
                else if (pick == 8)
                    fl = FLOOR_W'($urandom_range(top_floor_m, 255));
                else
                    fl = FLOOR_W'($urandom);
                send_word(cv, fl);
            end
        end

        drain_results();
        repeat (3) @(negedge clk);
        $display("Ran %0d ticks with %0d hall calls across %0d top-floor writes;",
                 n_taken, n_calls, n_cfg);
        $display("saw %0d dropped calls and %0d car arrivals.", n_drops, n_arrivals);
        if (n_fail == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
